/* hw/rtl/prim_st_pkg.sv */
// Shared types, widths and codes for the minimum spanning tree engine.
// No dependencies; used by the top level and the checker.
package prim_st_pkg;

    localparam int DEF_MAX_NODES = 32;
    localparam int DEF_MAX_EDGES = 256;

    localparam int NODE_W     = 6;
    localparam int SLOT_W     = 8;
    localparam int KEY_W      = 14;
    localparam int TOTAL_W    = 19;
    localparam int EDGE_CNT_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [KEY_W-1:0] INF_KEY = 14'd10000;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_NODE_COUNT = 1'b0,
        CFG_EDGE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic [NODE_W-1:0] end_a;
        logic [NODE_W-1:0] end_b;
        logic [KEY_W-1:0]  weight;
    } edge_t;

    typedef struct packed
    {
        logic              settled;
        logic [NODE_W-1:0] parent;
        logic [KEY_W-1:0]  key;
    } node_entry_t;

    localparam int EDGE_BITS = $bits(edge_t);
    localparam int NODE_BITS = $bits(node_entry_t);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_INIT,
        ST_PICK,
        ST_PICK_WAIT,
        ST_SETTLE,
        ST_RELAX,
        ST_RELAX_WAIT,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

endpackage

/* hw/rtl/prim_spanning_tree.sv */
// Top level of the dense Prim minimum spanning tree engine.
// Depends on prim_st_pkg and prim_st_ram (edge store and node table).
//
// Load items leave busy low. In a run with n nodes each round walks the node
// table once to pick the lightest unsettled node and then, if there are edge
// slots, walks the edge store once to relax its neighbors, one entry per cycle
// through the single read port of each memory. The n results then come out on
// consecutive cycles, one per result_valid pulse, and must be taken as they
// appear: there is no way to hold them off. busy stays high from the run
// transfer until the last result is loaded into the output register.
module prim_spanning_tree #(
    parameter int MAX_NODES = prim_st_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = prim_st_pkg::DEF_MAX_EDGES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [prim_st_pkg::SLOT_W-1:0]      edge_slot,
    input  logic [prim_st_pkg::NODE_W-1:0]      end_a,
    input  logic [prim_st_pkg::NODE_W-1:0]      end_b,
    input  logic [prim_st_pkg::KEY_W-1:0]       edge_weight,
    input  logic [prim_st_pkg::NODE_W-1:0]      start_node,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prim_st_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prim_st_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                result_valid,
    output logic [prim_st_pkg::NODE_W-1:0]      node,
    output logic [prim_st_pkg::NODE_W-1:0]      parent,
    output logic [prim_st_pkg::KEY_W-1:0]       link_weight,
    output logic [prim_st_pkg::TOTAL_W-1:0]     total_weight,
    output logic                                last
);

    import prim_st_pkg::*;

    localparam int NA_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    state_t state_reg, state_next;

    logic [NODE_W-1:0]     node_count_reg;
    logic [EDGE_CNT_W-1:0] edge_count_reg;

    logic [NODE_W-1:0]     n_reg;
    logic [EDGE_CNT_W-1:0] m_reg;
    logic [NODE_W-1:0]     start_reg;
    logic [NODE_W-1:0]     cnt_reg;
    logic [EDGE_CNT_W-1:0] ecnt_reg;
    logic [NODE_W-1:0]     round_reg;

    logic                  p1_v_reg;
    logic                  o1_v_reg;
    logic [NODE_W-1:0]     p1_idx_reg;

    logic                  best_v_reg;
    logic [NODE_W-1:0]     best_idx_reg;
    logic [KEY_W-1:0]      best_key_reg;
    logic [NODE_W-1:0]     best_parent_reg;

    logic                  e1_v_reg;
    logic                  r2_v_reg;
    logic [NODE_W-1:0]     r2_nb_reg;
    logic [KEY_W-1:0]      r2_w_reg;
    logic                  lw_v_reg;
    logic [NODE_W-1:0]     lw_nb_reg;
    logic [KEY_W-1:0]      lw_key_reg;

    logic [TOTAL_W-1:0]    acc_reg;

    logic                  result_valid_reg;
    logic [NODE_W-1:0]     node_reg;
    logic [NODE_W-1:0]     parent_reg;
    logic [KEY_W-1:0]      link_weight_reg;
    logic [TOTAL_W-1:0]    total_weight_reg;
    logic                  last_reg;

    logic [NODE_W-1:0]     n_clamp;
    logic [EDGE_CNT_W-1:0] m_clamp;
    logic [NODE_W-1:0]     n_last;
    logic                  run_go;
    logic                  load_go;
    logic                  round_end;
    logic                  round_final;

    edge_t                 edge_rd;
    node_entry_t           node_rd;
    logic [EDGE_BITS-1:0]  edge_rd_data;
    logic [NODE_BITS-1:0]  node_rd_data;

    logic                  hit_a;
    logic                  hit_b;
    logic [NODE_W-1:0]     nb1;
    logic                  match1;
    logic [KEY_W-1:0]      eff_key;
    logic                  relax_wr;
    logic [KEY_W-1:0]      emit_key;
    logic                  emit_last;
    logic [TOTAL_W-1:0]    emit_sum;

    logic                  node_wr_en;
    logic [NA_W-1:0]       node_wr_addr;
    node_entry_t           node_wr_data;
    logic [NA_W-1:0]       node_rd_addr;
    logic                  edge_wr_en;

    // ---------------------------------------------------------------- control terms
    assign n_clamp = (32'(node_count_reg) > MAX_NODES) ? NODE_W'(MAX_NODES) : node_count_reg;
    assign m_clamp = (32'(edge_count_reg) > MAX_EDGES) ? EDGE_CNT_W'(MAX_EDGES)
                                                       : edge_count_reg;
    assign n_last  = n_reg - NODE_W'(1);

    assign run_go  = (state_reg == ST_IDLE) && start && (opcode == OP_RUN);
    assign load_go = (state_reg == ST_IDLE) && start && (opcode == OP_LOAD);

    assign round_end = ((state_reg == ST_SETTLE) && (m_reg == '0))
                    || ((state_reg == ST_RELAX_WAIT) && !e1_v_reg && !r2_v_reg);
    assign round_final = (round_reg == n_last);

    // ---------------------------------------------------------------- relax datapath
    assign edge_rd = edge_t'(edge_rd_data);
    assign node_rd = node_entry_t'(node_rd_data);

    assign hit_a  = (edge_rd.end_a == best_idx_reg);
    assign hit_b  = (edge_rd.end_b == best_idx_reg);
    assign nb1    = hit_a ? edge_rd.end_b : edge_rd.end_a;
    assign match1 = (hit_a || hit_b) && (nb1 != '0) && (nb1 <= n_reg);

    // one write back in flight: forward it when the same node comes up again
    assign eff_key  = (lw_v_reg && (lw_nb_reg == r2_nb_reg)) ? lw_key_reg : node_rd.key;
    assign relax_wr = r2_v_reg && !node_rd.settled && (eff_key > r2_w_reg);

    assign emit_key  = node_rd.key;
    assign emit_last = (p1_idx_reg == n_last);
    assign emit_sum  = acc_reg + TOTAL_W'(emit_key);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_go && (n_clamp != '0))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = ST_PICK_WAIT;
                end
            end
            ST_PICK_WAIT:
            begin
                state_next = ST_SETTLE;
            end
            ST_SETTLE:
            begin
                if (m_reg == '0)
                begin
                    state_next = round_final ? ST_EMIT : ST_PICK;
                end
                else
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (ecnt_reg == (m_reg - EDGE_CNT_W'(1)))
                begin
                    state_next = ST_RELAX_WAIT;
                end
            end
            ST_RELAX_WAIT:
            begin
                if (!e1_v_reg && !r2_v_reg)
                begin
                    state_next = round_final ? ST_EMIT : ST_PICK;
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = ST_EMIT_WAIT;
                end
            end
            ST_EMIT_WAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs / memory control
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        node_wr_en   = 1'b0;
        node_wr_addr = NA_W'(best_idx_reg - NODE_W'(1));
        node_wr_data = '{settled: 1'b1, parent: best_parent_reg, key: best_key_reg};
        node_rd_addr = NA_W'(nb1 - NODE_W'(1));
        case (state_reg)
            ST_INIT:
            begin
                node_wr_en   = 1'b1;
                node_wr_addr = NA_W'(cnt_reg);
                node_wr_data = '{settled: 1'b0, parent: '0,
                                 key: ((cnt_reg + NODE_W'(1)) == start_reg) ? '0 : INF_KEY};
            end
            ST_PICK, ST_EMIT:
            begin
                node_rd_addr = NA_W'(cnt_reg);
            end
            ST_SETTLE:
            begin
                node_wr_en = 1'b1;
            end
            default:
            begin
                if (relax_wr)
                begin
                    node_wr_en   = 1'b1;
                    node_wr_addr = NA_W'(r2_nb_reg - NODE_W'(1));
                    node_wr_data = '{settled: 1'b0, parent: best_idx_reg, key: r2_w_reg};
                end
            end
        endcase
    end

    assign edge_wr_en = load_go && (32'(edge_slot) < MAX_EDGES);
    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------- memories
    prim_st_ram #(
        .WIDTH (EDGE_BITS),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr_en),
        .wr_addr (EA_W'(edge_slot)),
        .wr_data ({end_a, end_b, edge_weight}),
        .rd_addr (EA_W'(ecnt_reg)),
        .rd_data (edge_rd_data)
    );

    prim_st_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            node_count_reg   <= NODE_W'(1);
            edge_count_reg   <= '0;
            p1_v_reg         <= 1'b0;
            o1_v_reg         <= 1'b0;
            best_v_reg       <= 1'b0;
            e1_v_reg         <= 1'b0;
            r2_v_reg         <= 1'b0;
            lw_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_data[NODE_W-1:0];
                    CFG_EDGE_COUNT: edge_count_reg <= cfg_data[EDGE_CNT_W-1:0];
                    default:        ;
                endcase
            end
            p1_v_reg         <= (state_reg == ST_PICK);
            o1_v_reg         <= (state_reg == ST_EMIT);
            e1_v_reg         <= (state_reg == ST_RELAX);
            r2_v_reg         <= e1_v_reg && match1;
            lw_v_reg         <= relax_wr;
            result_valid_reg <= o1_v_reg;
            if ((state_next == ST_PICK) && (state_reg != ST_PICK))
            begin
                best_v_reg <= 1'b0;
            end
            else if (p1_v_reg && !node_rd.settled
                     && (!best_v_reg || (node_rd.key < best_key_reg)))
            begin
                best_v_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge clk)
    begin
        if (run_go)
        begin
            n_reg     <= n_clamp;
            m_reg     <= m_clamp;
            start_reg <= start_node;
        end

        if (state_reg != state_next)
        begin
            cnt_reg <= '0;
        end
        else if ((state_reg == ST_INIT) || (state_reg == ST_PICK) || (state_reg == ST_EMIT))
        begin
            cnt_reg <= cnt_reg + NODE_W'(1);
        end

        if (state_reg != state_next)
        begin
            ecnt_reg <= '0;
        end
        else if (state_reg == ST_RELAX)
        begin
            ecnt_reg <= ecnt_reg + EDGE_CNT_W'(1);
        end

        if (state_reg == ST_INIT)
        begin
            round_reg <= '0;
        end
        else if (round_end)
        begin
            round_reg <= round_reg + NODE_W'(1);
        end

        p1_idx_reg <= cnt_reg;

        if (p1_v_reg && !node_rd.settled && (!best_v_reg || (node_rd.key < best_key_reg)))
        begin
            best_idx_reg    <= p1_idx_reg + NODE_W'(1);
            best_key_reg    <= node_rd.key;
            best_parent_reg <= node_rd.parent;
        end

        r2_nb_reg  <= nb1;
        r2_w_reg   <= edge_rd.weight;
        lw_nb_reg  <= r2_nb_reg;
        lw_key_reg <= r2_w_reg;

        if (state_reg == ST_INIT)
        begin
            acc_reg <= '0;
        end
        else if (o1_v_reg)
        begin
            acc_reg <= emit_sum;
        end

        if (o1_v_reg)
        begin
            node_reg         <= p1_idx_reg + NODE_W'(1);
            parent_reg       <= node_rd.parent;
            link_weight_reg  <= emit_key;
            total_weight_reg <= emit_last ? emit_sum : '0;
            last_reg         <= emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign node         = node_reg;
    assign parent       = parent_reg;
    assign link_weight  = link_weight_reg;
    assign total_weight = total_weight_reg;
    assign last         = last_reg;

endmodule

/* hw/rtl/prim_st_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies; used for the edge store and the node table.
module prim_st_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/prim_st_checker.sv */
// Port-level checks for prim_spanning_tree, attached by the bind below.
// Depends on prim_st_pkg.
module prim_st_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           opcode,
    input logic                           result_valid,
    input logic [prim_st_pkg::NODE_W-1:0] node,
    input logic                           last
);

    import prim_st_pkg::*;

    // a load transfer never makes the block busy
    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_LOAD) |=> !busy)
        else $error("load transfer left the block busy");

    // results of a run come back to back with ascending node numbers
    a_result_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && (node == NODE_W'($past(node) + 1'b1)))
        else $error("result burst broken or out of order");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result after the last one of a run");

    // a result cannot appear out of an idle, quiet block
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !result_valid |=> !result_valid)
        else $error("result without a run in progress");

endmodule

bind prim_spanning_tree prim_st_checker u_prim_st_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .node         (node),
    .last         (last)
);
